### rtl/core/scanned_retransmit_timer_table_defines.svh
// ----------------------------------------------------------------------------
// Scanned retransmit timer table: assertion macros
// Concurrent assertion helpers on clk, disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef SCANNED_RETRANSMIT_TIMER_TABLE_DEFINES_SVH
`define SCANNED_RETRANSMIT_TIMER_TABLE_DEFINES_SVH

// Same-cycle implication.
`define SRTT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define SRTT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### rtl/core/srtt_pkg.sv
// ----------------------------------------------------------------------------
// srtt_pkg
// Shared constants of the scanned retransmit timer table.
// ----------------------------------------------------------------------------
package srtt_pkg;

  localparam int SLOTS_DEFAULT = 1024;

  localparam int SLOT_W  = 10;
  localparam int COUNT_W = 31;
  localparam int ENTRY_W = COUNT_W + 1;   // active flag on top of the count

  // request codes
  localparam logic [1:0] REQ_TICK = 2'd0;
  localparam logic [1:0] REQ_ARM  = 2'd1;
  localparam logic [1:0] REQ_STOP = 2'd2;

  // register indexes
  localparam logic REG_RELOAD_COUNT = 1'b0;

  localparam logic [COUNT_W-1:0] RELOAD_RESET = 31'd1000;

endpackage

### rtl/core/scanned_retransmit_timer_table.sv
// ----------------------------------------------------------------------------
// scanned_retransmit_timer_table
// Table of per-slot retransmit timers in one RAM, scanned one slot per tick.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake                | payload
//  --------+-----+--------------------------+-------------------------------
//  s_*     | in  | s_tvalid / s_tready      | tuser: req_type, tdata: slot_id
//  m_*     | out | m_tvalid / m_tready      | tdata: expired_slot
//  apb     | in  | psel, penable, pready=1  | reg 0 @ 0x0: reload_count
//
//  Arm, stop and unknown words are handled in S_RUN; a tick reads the RAM
//  in S_RUN, then modifies and writes back through the single write port
//  in S_TICK. After rst a clearing pass writes every entry inactive, with
//  s_tready low throughout. APB writes are taken at any time.
//  An expiry holds in the write-back cycle while the output register is
//  full and not being taken.
//
module scanned_retransmit_timer_table #(
  parameter int SLOTS = srtt_pkg::SLOTS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  // request stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [9:0] slot_id, [15:10] zero
  input  logic [1:0]  s_tuser,   // [1:0] req_type
  // expiry stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [9:0] expired_slot, [15:10] zero
  // config
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int PW = $clog2(SLOTS);
  localparam logic [PW-1:0] LAST = PW'(SLOTS - 1);

  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_RUN   = 3'b010,
    S_TICK  = 3'b100
  } state_t;

  state_t state, state_next;

  logic [PW-1:0] clr_idx;
  logic [PW-1:0] ptr;
  logic [PW-1:0] ptr_next;

  logic [srtt_pkg::COUNT_W-1:0] reload_count;

  logic                         ram_we;
  logic [PW-1:0]                ram_waddr;
  logic [srtt_pkg::ENTRY_W-1:0] ram_wdata;
  logic                         ram_re;
  logic [srtt_pkg::ENTRY_W-1:0] ram_rdata;

  logic                         accept;
  logic                         slot_ok;
  logic [PW-1:0]                slot_idx;
  logic                         ent_active;
  logic [srtt_pkg::COUNT_W-1:0] ent_count;
  logic                         out_free;
  logic                         load_out;
  logic [srtt_pkg::SLOT_W-1:0]  expired_slot;

  // config port: one register, decoded on paddr[2]
  assign pready = 1'b1;
  assign prdata = (paddr[2] == srtt_pkg::REG_RELOAD_COUNT) ? {1'b0, reload_count} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      reload_count <= srtt_pkg::RELOAD_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == srtt_pkg::REG_RELOAD_COUNT) begin
      reload_count <= pwdata[srtt_pkg::COUNT_W-1:0];
    end
  end

  // request decode
  assign s_tready = (state == S_RUN);
  assign accept   = s_tvalid && s_tready;
  assign slot_ok  = 32'(s_tdata[srtt_pkg::SLOT_W-1:0]) < SLOTS;
  assign slot_idx = PW'(s_tdata[srtt_pkg::SLOT_W-1:0]);
  assign ptr_next = (ptr == LAST) ? '0 : ptr + 1'b1;

  // entry read back for the scanned slot
  assign ent_active = ram_rdata[srtt_pkg::ENTRY_W-1];
  assign ent_count  = ram_rdata[srtt_pkg::COUNT_W-1:0];
  assign out_free   = !m_tvalid || m_tready;
  assign load_out   = (state == S_TICK) && ent_active && (ent_count == '0) && out_free;

  always_comb begin
    state_next = state;
    ram_we     = 1'b0;
    ram_waddr  = ptr;
    ram_wdata  = '0;
    ram_re     = 1'b0;
    unique case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_idx;
        if (clr_idx == LAST) begin
          state_next = S_RUN;
        end
      end
      S_RUN: begin
        if (accept) begin
          case (s_tuser)
            srtt_pkg::REQ_TICK: begin
              ram_re     = 1'b1;
              state_next = S_TICK;
            end
            srtt_pkg::REQ_ARM: begin
              ram_we    = slot_ok;
              ram_waddr = slot_idx;
              ram_wdata = {1'b1, reload_count};
            end
            srtt_pkg::REQ_STOP: begin
              // count of an inactive entry is never read: clear it
              ram_we    = slot_ok;
              ram_waddr = slot_idx;
            end
            default: ;
          endcase
        end
      end
      S_TICK: begin
        if (!ent_active) begin
          state_next = S_RUN;
        end else if (ent_count != '0) begin
          ram_we     = 1'b1;
          ram_wdata  = {1'b1, ent_count - 1'b1};
          state_next = S_RUN;
        end else if (out_free) begin
          ram_we     = 1'b1;        // expire: write inactive
          state_next = S_RUN;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_idx <= '0;
      ptr     <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_idx <= clr_idx + 1'b1;
      end
      if (accept && s_tuser == srtt_pkg::REQ_TICK) begin
        ptr <= ptr_next;
      end
    end
  end

  // output register
  assign expired_slot = srtt_pkg::SLOT_W'(ptr);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= {6'd0, expired_slot};
    end
  end

  srtt_ram #(
    .WIDTH (srtt_pkg::ENTRY_W),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ptr_next),
    .rdata (ram_rdata)
  );

`include "scanned_retransmit_timer_table_defines.svh"

  `SRTT_ASSERT_NEXT(a_tick_goes_to_wb, accept && s_tuser == srtt_pkg::REQ_TICK, state == S_TICK)
  `SRTT_ASSERT_NOW(a_wb_only_active, state == S_TICK && ram_we, ent_active)
  `SRTT_ASSERT_NOW(a_no_load_when_blocked, load_out, !m_tvalid || m_tready)
  `SRTT_ASSERT_NOW(a_ptr_in_range, 1'b1, 32'(ptr) < SLOTS)
  `SRTT_ASSERT_NEXT(a_expiry_shown, load_out, m_tvalid && m_tdata[9:0] == $past(expired_slot))

endmodule

### rtl/core/srtt_ram.sv
// ----------------------------------------------------------------------------
// srtt_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module srtt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
